// ===== src/rrhs_pkg.sv =====
`default_nettype none

package rrhs_pkg;

  localparam int CountBits = 32;
  localparam int SumBits = 48;
  localparam int SqBits = 64;
  localparam int RrBits = 16;
  localparam int OutBits = 16;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int BpmScale = 60000;
  localparam int JumpScale = 100;
  localparam int ProdBits = 16 + CountBits;
  localparam int DivSteps = SqBits;
  localparam int SqrtSteps = SqBits / 2;
  localparam int StepBits = $clog2(DivSteps);

  localparam logic [RrBits-1:0] RrMinReset = 16'd300;
  localparam logic [RrBits-1:0] RrMaxReset = 16'd2000;
  localparam logic [9:0] JumpReset = 10'd20;
  localparam logic [7:0] ReanchorReset = 8'd5;
  localparam logic [15:0] MinDiffsReset = 16'd10;

  typedef logic [CountBits-1:0] count_t;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_RR_MIN    = 3'd0,
    REG_RR_MAX    = 3'd1,
    REG_JUMP      = 3'd2,
    REG_REANCHOR  = 3'd3,
    REG_MIN_DIFFS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [RrBits-1:0] rr_min;
    logic [RrBits-1:0] rr_max;
    logic [9:0]        jump_percent;
    logic [7:0]        reanchor_after;
    logic [15:0]       min_diffs;
  } cfg_t;

  typedef struct packed {
    logic               accepted;
    count_t             accept_cnt;
    count_t             reject_cnt;
    count_t             diff_cnt;
    logic [SqBits-1:0]  sq_sum;
    logic [SumBits-1:0] int_sum;
    logic [15:0]        min_diffs;
  } snap_t;

endpackage

`default_nettype wire

// ===== src/rrhs_front.sv =====
`default_nettype none

module rrhs_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       take_i,
  input  wire logic                       opcode_i,
  input  wire logic [rrhs_pkg::RrBits-1:0] rr_ms_i,
  input  wire rrhs_pkg::cfg_t             cfg_i,
  output rrhs_pkg::snap_t                 snap_o
);

  logic [rrhs_pkg::RrBits-1:0]  prev_q, prev_d;
  logic                         chain_q, chain_d;
  logic [7:0]                   rir_q, rir_d;
  rrhs_pkg::count_t             acc_q, acc_d;
  rrhs_pkg::count_t             rej_q, rej_d;
  rrhs_pkg::count_t             diff_q, diff_d;
  logic [rrhs_pkg::SumBits-1:0] sum_q, sum_d;
  logic [rrhs_pkg::SqBits-1:0]  sq_q, sq_d;

  logic                         in_range;
  logic [rrhs_pkg::RrBits-1:0]  adiff;
  logic [25:0]                  lhs, rhs;
  logic                         jump;
  logic [7:0]                   rir_inc;
  logic [rrhs_pkg::SumBits:0]   sum_add;
  logic [31:0]                  sq_prod;
  logic [rrhs_pkg::SqBits:0]    sq_add;
  logic                         acc_flag;

  function automatic rrhs_pkg::count_t cnt_inc(rrhs_pkg::count_t c);
    return (&c) ? c : c + rrhs_pkg::count_t'(1);
  endfunction

  assign in_range = (rr_ms_i >= cfg_i.rr_min) && (rr_ms_i <= cfg_i.rr_max);
  assign adiff = (rr_ms_i >= prev_q) ? rr_ms_i - prev_q : prev_q - rr_ms_i;
  assign lhs = 26'(adiff) * 26'(rrhs_pkg::JumpScale);
  assign rhs = 26'(prev_q) * 26'(cfg_i.jump_percent);
  assign jump = lhs > rhs;
  assign rir_inc = (rir_q == 8'hFF) ? rir_q : rir_q + 8'd1;
  assign sum_add = {1'b0, sum_q} + (rrhs_pkg::SumBits + 1)'(rr_ms_i);
  assign sq_prod = 32'(adiff) * 32'(adiff);
  assign sq_add = {1'b0, sq_q} + (rrhs_pkg::SqBits + 1)'(sq_prod);

  always_comb begin
    logic take;
    take = 1'b0;
    prev_d = prev_q;
    chain_d = chain_q;
    rir_d = rir_q;
    acc_d = acc_q;
    rej_d = rej_q;
    diff_d = diff_q;
    sum_d = sum_q;
    sq_d = sq_q;
    if (rrhs_pkg::op_e'(opcode_i) == rrhs_pkg::OP_CLEAR) begin
      prev_d = '0;
      chain_d = 1'b0;
      rir_d = '0;
      acc_d = '0;
      rej_d = '0;
      diff_d = '0;
      sum_d = '0;
      sq_d = '0;
    end else if (!in_range) begin
      rej_d = cnt_inc(rej_q);
      chain_d = 1'b0;
      rir_d = rir_inc;
    end else if (prev_q == '0) begin
      take = 1'b1;
    end else if (jump) begin
      if (rir_inc >= cfg_i.reanchor_after) begin
        take = 1'b1;
      end else begin
        chain_d = 1'b0;
        rir_d = rir_inc;
        rej_d = cnt_inc(rej_q);
      end
    end else begin
      if (chain_q) begin
        sq_d = sq_add[rrhs_pkg::SqBits] ? '1 : sq_add[rrhs_pkg::SqBits-1:0];
        diff_d = cnt_inc(diff_q);
      end
      take = 1'b1;
    end
    if (take) begin
      acc_d = cnt_inc(acc_q);
      sum_d = sum_add[rrhs_pkg::SumBits] ? '1 : sum_add[rrhs_pkg::SumBits-1:0];
      prev_d = rr_ms_i;
      chain_d = 1'b1;
      rir_d = '0;
    end
    acc_flag = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      chain_q <= 1'b0;
      rir_q <= '0;
      acc_q <= '0;
      rej_q <= '0;
      diff_q <= '0;
      sum_q <= '0;
      sq_q <= '0;
    end else if (take_i) begin
      prev_q <= prev_d;
      chain_q <= chain_d;
      rir_q <= rir_d;
      acc_q <= acc_d;
      rej_q <= rej_d;
      diff_q <= diff_d;
      sum_q <= sum_d;
      sq_q <= sq_d;
    end
  end

  always_comb begin
    snap_o.accepted = acc_flag;
    snap_o.accept_cnt = acc_d;
    snap_o.reject_cnt = rej_d;
    snap_o.diff_cnt = diff_d;
    snap_o.sq_sum = sq_d;
    snap_o.int_sum = sum_d;
    snap_o.min_diffs = cfg_i.min_diffs;
  end

endmodule

`default_nettype wire

// ===== src/rrhs_queue.sv =====
`default_nettype none

module rrhs_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire rrhs_pkg::snap_t wdata_i,
  input  wire logic            rd_i,
  output rrhs_pkg::snap_t      rdata_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int PtrBits = rrhs_pkg::QueuePtrBits;
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(rrhs_pkg::QueueDepth - 1);

  rrhs_pkg::snap_t        mem_q [rrhs_pkg::QueueDepth];
  logic [PtrBits-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]       cnt_q, cnt_d;
  logic                   do_wr, do_rd;

  assign full_o = (cnt_q == (PtrBits + 1)'(rrhs_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + (PtrBits + 1)'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - (PtrBits + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/rrhs_back.sv =====
`default_nettype none

module rrhs_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire rrhs_pkg::snap_t              q_data_i,
  output logic                              q_pop_o,
  input  wire logic                         out_pop_i,
  output logic                              out_valid_o,
  output logic                              accepted_o,
  output rrhs_pkg::count_t                  acc_cnt_o,
  output rrhs_pkg::count_t                  rej_cnt_o,
  output logic [rrhs_pkg::OutBits-1:0]      rmssd_o,
  output logic [rrhs_pkg::OutBits-1:0]      bpm_o
);

  localparam int CB = rrhs_pkg::CountBits;
  localparam int SB = rrhs_pkg::SumBits;
  localparam int QB = rrhs_pkg::SqBits;
  localparam int OB = rrhs_pkg::OutBits;
  localparam int TB = rrhs_pkg::StepBits;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SQRT = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  rrhs_pkg::snap_t   snap_q;
  logic [TB-1:0]     step_q;
  logic [QB-1:0]     num1_q;
  logic [CB-1:0]     rem1_q;
  logic [QB-1:0]     num2_q;
  logic [SB-1:0]     rem2_q;
  logic [QB-1:0]     rest_q, root_q, bit_q;
  logic              out_valid_q;
  logic              acc_q;
  rrhs_pkg::count_t  acc_cnt_q, rej_cnt_q;
  logic [OB-1:0]     rmssd_q, bpm_q;

  logic [CB:0]       sh1;
  logic              ge1;
  logic [SB:0]       sh2;
  logic              ge2;
  logic [QB-1:0]     trial;
  logic              ge_sq;
  logic [rrhs_pkg::ProdBits-1:0] prod;
  logic              rmssd_ok, bpm_ok, out_free;

  assign sh1 = {rem1_q, num1_q[QB-1]};
  assign ge1 = sh1 >= {1'b0, snap_q.diff_cnt};
  assign sh2 = {rem2_q, num2_q[QB-1]};
  assign ge2 = sh2 >= {1'b0, snap_q.int_sum};
  assign trial = root_q + bit_q;
  assign ge_sq = rest_q >= trial;
  assign prod = rrhs_pkg::ProdBits'(rrhs_pkg::BpmScale) * rrhs_pkg::ProdBits'(snap_q.accept_cnt);
  assign rmssd_ok = (snap_q.diff_cnt != '0) && (32'(snap_q.diff_cnt) >= 32'(snap_q.min_diffs));
  assign bpm_ok = (snap_q.accept_cnt != '0) && (snap_q.int_sum != '0);
  assign out_free = !out_valid_q || out_pop_i;
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!q_empty_i) state_d = S_MUL;
      S_MUL:  state_d = S_DIV;
      S_DIV:  if (step_q == TB'(rrhs_pkg::DivSteps - 1)) state_d = S_SQRT;
      S_SQRT: if (step_q == TB'(rrhs_pkg::SqrtSteps - 1)) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        snap_q <= q_data_i;
      end
      S_MUL: begin
        num1_q <= snap_q.sq_sum;
        rem1_q <= '0;
        num2_q <= QB'(prod);
        rem2_q <= '0;
        step_q <= '0;
      end
      S_DIV: begin
        rem1_q <= ge1 ? CB'(sh1 - {1'b0, snap_q.diff_cnt}) : sh1[CB-1:0];
        num1_q <= {num1_q[QB-2:0], ge1};
        rem2_q <= ge2 ? SB'(sh2 - {1'b0, snap_q.int_sum}) : sh2[SB-1:0];
        num2_q <= {num2_q[QB-2:0], ge2};
        step_q <= step_q + TB'(1);
        rest_q <= {num1_q[QB-2:0], ge1};
        root_q <= '0;
        bit_q <= QB'(1) << (QB - 2);
      end
      S_SQRT: begin
        if (ge_sq) begin
          rest_q <= rest_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        step_q <= step_q + TB'(1);
      end
      S_DONE: begin
        if (out_free) begin
          acc_q <= snap_q.accepted;
          acc_cnt_q <= snap_q.accept_cnt;
          rej_cnt_q <= snap_q.reject_cnt;
          if (!rmssd_ok) begin
            rmssd_q <= '0;
          end else if (|root_q[QB-1:OB]) begin
            rmssd_q <= '1;
          end else begin
            rmssd_q <= root_q[OB-1:0];
          end
          if (!bpm_ok) begin
            bpm_q <= '0;
          end else if (|num2_q[QB-1:OB]) begin
            bpm_q <= '1;
          end else begin
            bpm_q <= num2_q[OB-1:0];
          end
        end
      end
      default: begin
        step_q <= step_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o = acc_q;
  assign acc_cnt_o = acc_cnt_q;
  assign rej_cnt_o = rej_cnt_q;
  assign rmssd_o = rmssd_q;
  assign bpm_o = bpm_q;

endmodule

`default_nettype wire

// ===== src/rr_interval_hrv_stats_core.sv =====
// An item accepted at the input waits in the queue; the back end takes it from
// the queue, forms the rate product, runs the serial dividers, runs the square root and
// registers the result.
// The back end takes no new item until it is through with the last one; the queue holds
// up to four classified items while the back end is busy.
// Reset: asynchronous and active low; it clears all statistics, empties the
// queue and returns the configuration registers to their default values.
`default_nettype none

module rr_interval_hrv_stats_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rrhs_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  wire logic [rrhs_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              opcode_i,
  input  wire logic [15:0]                       rr_ms_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   accepted_o,
  output logic [31:0]                            accepted_count_o,
  output logic [31:0]                            rejected_count_o,
  output logic [15:0]                            rmssd_ms_o,
  output logic [15:0]                            mean_bpm_o
);

  rrhs_pkg::cfg_t   cfg_q;
  rrhs_pkg::snap_t  front_snap, q_data;
  logic             take, q_full, q_empty, q_pop, out_valid;
  rrhs_pkg::count_t acc_cnt, rej_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rr_min <= rrhs_pkg::RrMinReset;
      cfg_q.rr_max <= rrhs_pkg::RrMaxReset;
      cfg_q.jump_percent <= rrhs_pkg::JumpReset;
      cfg_q.reanchor_after <= rrhs_pkg::ReanchorReset;
      cfg_q.min_diffs <= rrhs_pkg::MinDiffsReset;
    end else if (cfg_we_i) begin
      case (rrhs_pkg::cfg_reg_e'(cfg_idx_i))
        rrhs_pkg::REG_RR_MIN:    cfg_q.rr_min <= cfg_wdata_i;
        rrhs_pkg::REG_RR_MAX:    cfg_q.rr_max <= cfg_wdata_i;
        rrhs_pkg::REG_JUMP:      cfg_q.jump_percent <= cfg_wdata_i[9:0];
        rrhs_pkg::REG_REANCHOR:  cfg_q.reanchor_after <= cfg_wdata_i[7:0];
        rrhs_pkg::REG_MIN_DIFFS: cfg_q.min_diffs <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign take = push && !q_full;
  assign full = q_full;

  rrhs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .opcode_i (opcode_i),
    .rr_ms_i  (rr_ms_i),
    .cfg_i    (cfg_q),
    .snap_o   (front_snap)
  );

  rrhs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (take),
    .wdata_i (front_snap),
    .rd_i    (q_pop),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rrhs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop && out_valid),
    .out_valid_o (out_valid),
    .accepted_o  (accepted_o),
    .acc_cnt_o   (acc_cnt),
    .rej_cnt_o   (rej_cnt),
    .rmssd_o     (rmssd_ms_o),
    .bpm_o       (mean_bpm_o)
  );

  assign empty = !out_valid;
  assign accepted_count_o = 32'(acc_cnt);
  assign rejected_count_o = 32'(rej_cnt);

endmodule

`default_nettype wire

// ===== sim/hrv_stats_checker.sv =====
`timescale 1ns / 100ps

module hrv_stats_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rrhs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [rrhs_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  input  logic                                push,
  input  logic                                full,
  input  logic                                opcode_i,
  input  logic [15:0]                         rr_ms_i,
  input  logic                                empty,
  input  logic                                pop,
  input  logic                                accepted_o,
  input  logic [31:0]                         accepted_count_o,
  input  logic [31:0]                         rejected_count_o,
  input  logic [15:0]                         rmssd_ms_o,
  input  logic [15:0]                         mean_bpm_o,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import rrhs_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic [31:0] acc_cnt;
    logic [31:0] rej_cnt;
    logic [15:0] rmssd;
    logic [15:0] bpm;
  } hrv_result_t;

  hrv_result_t beat_results_q[$];

  logic [15:0] rr_lo;
  logic [15:0] rr_hi;
  logic [9:0]  jump_pct;
  logic [7:0]  reanchor_lim;
  logic [15:0] diffs_needed;

  logic [15:0] prev_rr;
  logic        chain_ok;
  logic [7:0]  reject_run;
  logic [31:0] n_accept;
  logic [31:0] n_reject;
  logic [31:0] n_diff;
  logic [47:0] rr_sum;
  logic [63:0] sq_sum;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= v) root = trial;
    end
    return root;
  endfunction

  task automatic clear_stats();
    prev_rr = '0;
    chain_ok = 1'b0;
    reject_run = '0;
    n_accept = '0;
    n_reject = '0;
    n_diff = '0;
    rr_sum = '0;
    sq_sum = '0;
  endtask

  task automatic take_beat(input logic [15:0] rr);
    logic [48:0] s;
    n_accept = bump(n_accept);
    s = {1'b0, rr_sum} + 49'(rr);
    rr_sum = s[48] ? '1 : s[47:0];
    prev_rr = rr;
    chain_ok = 1'b1;
    reject_run = '0;
  endtask

  task automatic extend_reject_run();
    chain_ok = 1'b0;
    if (reject_run != 8'hFF) reject_run = reject_run + 8'd1;
  endtask

  task automatic predict_beat(input op_e op, input logic [15:0] rr, output hrv_result_t res);
    logic        took;
    logic [15:0] gap;
    logic [63:0] sq;
    logic [64:0] sq_next;
    logic [31:0] root;
    logic [63:0] rate;
    took = 1'b0;
    if (op == OP_CLEAR) begin
      clear_stats();
    end else if (rr < rr_lo || rr > rr_hi) begin
      n_reject = bump(n_reject);
      extend_reject_run();
    end else if (prev_rr == '0) begin
      take_beat(rr);
      took = 1'b1;
    end else begin
      gap = (rr >= prev_rr) ? rr - prev_rr : prev_rr - rr;
      if (64'(gap) * 64'(JumpScale) > 64'(prev_rr) * 64'(jump_pct)) begin
        extend_reject_run();
        if (reject_run >= reanchor_lim) begin
          take_beat(rr);
          took = 1'b1;
        end else begin
          n_reject = bump(n_reject);
        end
      end else begin
        if (chain_ok) begin
          sq = 64'(gap) * 64'(gap);
          sq_next = {1'b0, sq_sum} + {1'b0, sq};
          sq_sum = sq_next[64] ? '1 : sq_next[63:0];
          n_diff = bump(n_diff);
        end
        take_beat(rr);
        took = 1'b1;
      end
    end
    res.accepted = took;
    res.acc_cnt = n_accept;
    res.rej_cnt = n_reject;
    res.rmssd = '0;
    res.bpm = '0;
    if (n_diff != '0 && n_diff >= 32'(diffs_needed)) begin
      root = isqrt64(sq_sum / 64'(n_diff));
      res.rmssd = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
    end
    if (n_accept != '0 && rr_sum != '0) begin
      rate = (64'(BpmScale) * 64'(n_accept)) / 64'(rr_sum);
      res.bpm = (rate > 64'hFFFF) ? 16'hFFFF : rate[15:0];
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t ns: %s is %0d, predicted %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    hrv_result_t want;
    hrv_result_t got;
    if (!rst_ni) begin
      rr_lo = RrMinReset;
      rr_hi = RrMaxReset;
      jump_pct = JumpReset;
      reanchor_lim = ReanchorReset;
      diffs_needed = MinDiffsReset;
      clear_stats();
      beat_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_RR_MIN:    rr_lo = cfg_wdata_i;
          REG_RR_MAX:    rr_hi = cfg_wdata_i;
          REG_JUMP:      jump_pct = cfg_wdata_i[9:0];
          REG_REANCHOR:  reanchor_lim = cfg_wdata_i[7:0];
          REG_MIN_DIFFS: diffs_needed = cfg_wdata_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        predict_beat(op_e'(opcode_i), rr_ms_i, want);
        beat_results_q.push_back(want);
      end
      if (pop && !empty) begin
        got = {accepted_o, accepted_count_o, rejected_count_o, rmssd_ms_o, mean_bpm_o};
        if (beat_results_q.size() == 0) begin
          report_mismatch("result transfer with no item outstanding, accepted_count",
                          64'(got.acc_cnt), 64'd0);
        end else begin
          want = beat_results_q.pop_front();
          if (got.accepted != want.accepted)
            report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
          if (got.acc_cnt != want.acc_cnt)
            report_mismatch("accepted_count", 64'(got.acc_cnt), 64'(want.acc_cnt));
          if (got.rej_cnt != want.rej_cnt)
            report_mismatch("rejected_count", 64'(got.rej_cnt), 64'(want.rej_cnt));
          if (got.rmssd != want.rmssd)
            report_mismatch("rmssd_ms", 64'(got.rmssd), 64'(want.rmssd));
          if (got.bpm != want.bpm)
            report_mismatch("mean_bpm", 64'(got.bpm), 64'(want.bpm));
        end
      end
    end
    pending_o = beat_results_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rrhs_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 2500;
  localparam int DrainCycles = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_wdata = '0;
  logic                  push = 1'b0;
  logic                  full;
  op_e                   beat_op = OP_ADD;
  logic [15:0]           rr_ms = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  accepted;
  logic [31:0]           accepted_count;
  logic [31:0]           rejected_count;
  logic [15:0]           rmssd_ms;
  logic [15:0]           mean_bpm;

  int fail_count;
  int pending;
  int cycles = 0;
  int beats_sent = 0;
  int results_taken = 0;
  bit send_burst = 1'b0;
  bit drain_burst = 1'b0;
  bit hold_req = 1'b0;
  int cur_lo = RrMinReset;
  int cur_hi = RrMaxReset;
  int cur_jump = JumpReset;

  always #5 clk = ~clk;

  rr_interval_hrv_stats_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .push             (push),
    .full             (full),
    .opcode_i         (beat_op),
    .rr_ms_i          (rr_ms),
    .empty            (empty),
    .pop              (pop),
    .accepted_o       (accepted),
    .accepted_count_o (accepted_count),
    .rejected_count_o (rejected_count),
    .rmssd_ms_o       (rmssd_ms),
    .mean_bpm_o       (mean_bpm)
  );

  hrv_stats_checker hrv_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .push             (push),
    .full             (full),
    .opcode_i         (beat_op),
    .rr_ms_i          (rr_ms),
    .empty            (empty),
    .pop              (pop),
    .accepted_o       (accepted),
    .accepted_count_o (accepted_count),
    .rejected_count_o (rejected_count),
    .rmssd_ms_o       (rmssd_ms),
    .mean_bpm_o       (mean_bpm),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_beat(input op_e op, input logic [15:0] rr);
    int gap;
    if (beats_sent % 50 == 0) send_burst = ($urandom_range(0, 2) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    beat_op = op;
    rr_ms = rr;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic quiesce();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_regs(input int lo, input int hi, input int jump, input int reanchor,
                              input int diffs);
    quiesce();
    write_reg(REG_RR_MIN, 16'(lo));
    write_reg(REG_RR_MAX, 16'(hi));
    write_reg(REG_JUMP, 16'(jump));
    write_reg(REG_REANCHOR, 16'(reanchor));
    write_reg(REG_MIN_DIFFS, 16'(diffs));
    cur_lo = lo;
    cur_hi = hi;
    cur_jump = jump;
  endtask

  // Mostly a steady rhythm that drifts slowly and stays inside the jump limit,
  // mixed with outliers, raw noise and the occasional clear.
  task automatic run_rhythm(input int count);
    int base;
    int rr;
    int pick;
    int span;
    int drift;
    base = (cur_lo + cur_hi) / 2;
    if (base == 0) base = 1;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_beat(OP_CLEAR, 16'($urandom_range(0, 65535)));
      end else if (pick < 9) begin
        send_beat(OP_ADD, 16'($urandom_range(0, 65535)));
      end else begin
        drift = base / 100;
        base = base + int'($urandom_range(0, 2 * drift)) - drift;
        if (base < cur_lo) base = cur_lo;
        if (base > cur_hi) base = cur_hi;
        if (base < 1) base = 1;
        if (pick < 16) begin
          rr = ($urandom_range(0, 1) == 1) ? base + base / 2 + int'($urandom_range(0, base / 4))
                                           : base / 2;
        end else begin
          span = base * cur_jump / 250;
          rr = base + int'($urandom_range(0, 2 * span)) - span;
        end
        if (rr < 0) rr = 0;
        if (rr > 65535) rr = 65535;
        send_beat(OP_ADD, 16'(rr));
      end
    end
  endtask

  initial begin : result_drain
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        pop = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      if (results_taken % 40 == 0) drain_burst = ($urandom_range(0, 2) == 0);
      gap = drain_burst ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: window checks, jump rejects and a forced re-anchor.
    send_beat(OP_CLEAR, 16'd0);
    send_beat(OP_ADD, 16'd800);
    send_beat(OP_ADD, 16'd820);
    send_beat(OP_ADD, 16'd299);
    send_beat(OP_ADD, 16'd2001);
    send_beat(OP_ADD, 16'd300);
    send_beat(OP_ADD, 16'd2000);
    send_beat(OP_ADD, 16'd1500);
    send_beat(OP_ADD, 16'd1510);
    send_beat(OP_ADD, 16'hFFFF);
    send_beat(OP_ADD, 16'd0);

    // Open window: zero intervals keep the chain unanchored and the rate saturates.
    program_regs(0, 65535, 1023, 255, 1);
    send_beat(OP_CLEAR, 16'hFFFF);
    send_beat(OP_ADD, 16'd0);
    send_beat(OP_ADD, 16'd0);
    send_beat(OP_ADD, 16'd1);
    send_beat(OP_ADD, 16'd2);
    send_beat(OP_ADD, 16'hFFFF);

    // Inverted window rejects everything.
    program_regs(500, 400, 0, 0, 0);
    send_beat(OP_ADD, 16'd450);
    send_beat(OP_ADD, 16'd400);

    // No jump allowed and no reject run needed: every change re-anchors at once.
    program_regs(0, 65535, 0, 0, 0);
    send_beat(OP_CLEAR, 16'd0);
    send_beat(OP_ADD, 16'd1000);
    send_beat(OP_ADD, 16'd1000);
    send_beat(OP_ADD, 16'd1001);
    send_beat(OP_ADD, 16'd1001);

    program_regs(RrMinReset, RrMaxReset, JumpReset, ReanchorReset, MinDiffsReset);
    run_rhythm(200);

    program_regs($urandom_range(250, 450), $urandom_range(1200, 2200), $urandom_range(5, 40),
                 $urandom_range(1, 8), $urandom_range(1, 30));
    run_rhythm(190);

    // The result side stalls for a long stretch here, so the block backs up.
    program_regs($urandom_range(250, 450), $urandom_range(1200, 2200), $urandom_range(5, 40),
                 $urandom_range(1, 8), $urandom_range(1, 30));
    hold_req = 1'b1;
    run_rhythm(190);

    program_regs(0, 65535, 1023, 255, 65535);
    run_rhythm(190);

    program_regs(300, 2000, 0, 0, 0);
    run_rhythm(190);

    program_regs($urandom_range(200, 500), $urandom_range(1000, 3000), $urandom_range(0, 1023),
                 $urandom_range(0, 255), $urandom_range(0, 40));
    run_rhythm(190);

    quiesce();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rrhs_pkg.sv
src/rrhs_front.sv
src/rrhs_queue.sv
src/rrhs_back.sv
src/rr_interval_hrv_stats_core.sv
sim/hrv_stats_checker.sv
sim/tb.sv
